>>> src/fep_pkg.sv
package fep_pkg;

	// Flash geometry and session limits
	localparam int SECTOR_BYTES     = 4096;
	localparam int SECTORS_IN_BLOCK = 16;
	localparam int MAX_BLOCK_BYTES  = 16384;
	localparam int MAX_ERASES       = 5;

	localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
	localparam int BLOCK_SHIFT  = $clog2(SECTORS_IN_BLOCK);

	// Field widths
	localparam int ADDR_W   = 32;
	localparam int COUNT_W  = 20;
	localparam int BYTES_W  = 16;
	localparam int LEN_W    = 15;
	localparam int CURSOR_W = 20;
	localparam int LEFT_W   = 24;

	// Derived widths
	localparam int PROD_W   = COUNT_W + BYTES_W;
	localparam int CEIL_W   = PROD_W + 1;
	localparam int LIMIT_W  = BYTES_W + 1;
	localparam int SUM_W    = ADDR_W + 1;
	localparam int END_W    = SUM_W - SECTOR_SHIFT;
	localparam int CMP_W    = (END_W > CURSOR_W) ? END_W : CURSOR_W;
	localparam int NERASE_W = $clog2(MAX_ERASES + 1);

	localparam logic [LEFT_W-1:0] LEFT_MAX = '1;

	// Front-to-back queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		REQ_BEGIN  = 2'd0,
		REQ_DATA   = 2'd1,
		REQ_END    = 2'd2,
		REQ_REPORT = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		CMD_STATUS       = 3'd0,
		CMD_UNLOCK       = 3'd1,
		CMD_ERASE_BLOCK  = 3'd2,
		CMD_ERASE_SECTOR = 3'd3,
		CMD_WRITE        = 3'd4
	} cmd_kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_SIZE = 2'd1,
		ST_OP_FAIL  = 2'd2,
		ST_NO_MODE  = 2'd3
	} status_t;

	// Classified operation handed from front to back
	typedef enum logic [2:0] {
		OP_BAD_SIZE,
		OP_BEGIN,
		OP_DATA,
		OP_END,
		OP_REPORT
	} op_kind_t;

	typedef enum logic {
		BK_IDLE,
		BK_ERASE
	} back_state_t;

	typedef struct packed {
		req_type_t           req_type;
		logic [ADDR_W-1:0]   start_address;
		logic [COUNT_W-1:0]  block_count;
		logic [BYTES_W-1:0]  block_bytes;
		logic [LEN_W-1:0]    data_length;
		logic                op_failed;
	} req_t;

	typedef struct packed {
		cmd_kind_t           cmd_kind;
		logic [ADDR_W-1:0]   cmd_target;
		logic [LEN_W-1:0]    cmd_length;
		status_t             status;
		logic                session_active;
		logic                last;
	} rsp_t;

	typedef struct packed {
		op_kind_t            kind;
		logic [ADDR_W-1:0]   start_address;
		logic [LEFT_W-1:0]   sectors_left;
		logic [LEN_W-1:0]    data_length;
		logic                op_failed;
	} op_t;

endpackage

>>> src/fep_front.sv
module fep_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  fep_pkg::req_t   req,
	output logic            push,
	output fep_pkg::op_t    push_op,
	input  logic            queue_full
);

	logic                        valid_s1;
	fep_pkg::op_kind_t           kind_s1;
	logic [fep_pkg::ADDR_W-1:0]  start_s1;
	logic [fep_pkg::LEN_W-1:0]   len_s1;
	logic                        failed_s1;
	logic [fep_pkg::PROD_W-1:0]  prod_s1;

	fep_pkg::op_kind_t           kind_in;
	logic                        accept;
	logic [fep_pkg::CEIL_W-1:0]  ceil_sum;
	logic [fep_pkg::CEIL_W-1:0]  secs;
	logic [fep_pkg::LEFT_W-1:0]  left;

	// Hold the stage while the queue is full
	assign push      = valid_s1 && !queue_full;
	assign req_stall = valid_s1 && queue_full;
	assign accept    = req_valid && !req_stall;

	// Classify the incoming word
	always_comb begin
		unique case (req.req_type)
			fep_pkg::REQ_BEGIN: begin
				if ({1'b0, req.block_bytes} >
				    fep_pkg::LIMIT_W'(fep_pkg::MAX_BLOCK_BYTES))
					kind_in = fep_pkg::OP_BAD_SIZE;
				else
					kind_in = fep_pkg::OP_BEGIN;
			end
			fep_pkg::REQ_DATA: kind_in = fep_pkg::OP_DATA;
			fep_pkg::REQ_END:  kind_in = fep_pkg::OP_END;
			default:           kind_in = fep_pkg::OP_REPORT;
		endcase
	end

	// Register the word and the announced byte total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= kind_in;
			start_s1  <= req.start_address;
			len_s1    <= req.data_length;
			failed_s1 <= req.op_failed;
			prod_s1   <= fep_pkg::PROD_W'(req.block_count) * fep_pkg::PROD_W'(req.block_bytes);
		end
	end

	// Round the total up to whole sectors and saturate
	always_comb begin
		ceil_sum = fep_pkg::CEIL_W'(prod_s1) + fep_pkg::CEIL_W'(fep_pkg::SECTOR_BYTES - 1);
		secs     = ceil_sum >> fep_pkg::SECTOR_SHIFT;
		if (secs > fep_pkg::CEIL_W'(fep_pkg::LEFT_MAX))
			left = fep_pkg::LEFT_MAX;
		else
			left = secs[fep_pkg::LEFT_W-1:0];
	end

	always_comb begin
		push_op.kind          = kind_s1;
		push_op.start_address = start_s1;
		push_op.sectors_left  = left;
		push_op.data_length   = len_s1;
		push_op.op_failed     = failed_s1;
	end

endmodule

>>> src/fep_queue.sv
module fep_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fep_pkg::op_t    push_op,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output fep_pkg::op_t    head
);

	fep_pkg::op_t                entry_q [fep_pkg::QUEUE_DEPTH];
	logic [fep_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [fep_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [fep_pkg::QCNT_W-1:0]  count_q;
	logic                        do_push;
	logic                        do_pop;

	assign full       = count_q == fep_pkg::QCNT_W'(fep_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Store the pushed word
	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_op;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				if (wr_ptr_q == fep_pkg::QPTR_W'(fep_pkg::QUEUE_DEPTH - 1))
					wr_ptr_q <= '0;
				else
					wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				if (rd_ptr_q == fep_pkg::QPTR_W'(fep_pkg::QUEUE_DEPTH - 1))
					rd_ptr_q <= '0;
				else
					rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> src/fep_back.sv
module fep_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  fep_pkg::op_t    head,
	output logic            pop,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output fep_pkg::rsp_t   rsp
);

	fep_pkg::back_state_t          state_q;
	fep_pkg::back_state_t          state_d;

	logic                          mode_q;
	logic [fep_pkg::ADDR_W-1:0]    waddr_q;
	logic [fep_pkg::CURSOR_W-1:0]  cursor_q;
	logic [fep_pkg::LEFT_W-1:0]    left_q;
	logic                          sticky_q;
	logic [fep_pkg::END_W-1:0]     end_q;
	logic [fep_pkg::NERASE_W-1:0]  nerase_q;

	logic                          out_valid_q;
	fep_pkg::rsp_t                 out_q;

	logic                          out_free;
	logic                          emit;
	fep_pkg::rsp_t                 res;
	logic                          start_data;
	logic                          erase_blk;
	logic                          erase_sec;
	logic                          do_write;
	logic                          do_begin;
	logic                          do_end;
	logic                          do_report;
	logic                          more_erase;
	logic                          blk_ok;
	logic [fep_pkg::SUM_W-1:0]     end_sum;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Erase decisions for the current cursor
	assign more_erase = (nerase_q < fep_pkg::NERASE_W'(fep_pkg::MAX_ERASES)) &&
	                    (fep_pkg::CMP_W'(cursor_q) < fep_pkg::CMP_W'(end_q));
	assign blk_ok     = (cursor_q[fep_pkg::BLOCK_SHIFT-1:0] == '0) &&
	                    (left_q > fep_pkg::LEFT_W'(fep_pkg::SECTORS_IN_BLOCK));
	assign end_sum    = fep_pkg::SUM_W'(waddr_q) + fep_pkg::SUM_W'(head.data_length) +
	                    fep_pkg::SUM_W'(fep_pkg::SECTOR_BYTES - 1);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fep_pkg::BK_IDLE:  if (start_data) state_d = fep_pkg::BK_ERASE;
			fep_pkg::BK_ERASE: if (do_write) state_d = fep_pkg::BK_IDLE;
			default:           state_d = fep_pkg::BK_IDLE;
		endcase
	end

	// Result and state-update decisions
	always_comb begin
		emit                = 1'b0;
		pop                 = 1'b0;
		start_data          = 1'b0;
		erase_blk           = 1'b0;
		erase_sec           = 1'b0;
		do_write            = 1'b0;
		do_begin            = 1'b0;
		do_end              = 1'b0;
		do_report           = 1'b0;
		res.cmd_kind        = fep_pkg::CMD_STATUS;
		res.cmd_target      = '0;
		res.cmd_length      = '0;
		res.status          = fep_pkg::ST_OK;
		res.session_active  = mode_q;
		res.last            = 1'b1;
		unique case (state_q)
			fep_pkg::BK_IDLE: begin
				if (head_valid && out_free) begin
					unique case (head.kind)
						fep_pkg::OP_BAD_SIZE: begin
							emit       = 1'b1;
							pop        = 1'b1;
							res.status = fep_pkg::ST_BAD_SIZE;
						end
						fep_pkg::OP_BEGIN: begin
							emit               = 1'b1;
							pop                = 1'b1;
							do_begin           = 1'b1;
							res.cmd_kind       = fep_pkg::CMD_UNLOCK;
							res.session_active = 1'b1;
						end
						fep_pkg::OP_DATA: begin
							if (mode_q) begin
								start_data = 1'b1;
							end else begin
								emit       = 1'b1;
								pop        = 1'b1;
								res.status = fep_pkg::ST_NO_MODE;
							end
						end
						fep_pkg::OP_END: begin
							emit               = 1'b1;
							pop                = 1'b1;
							do_end             = 1'b1;
							res.session_active = 1'b0;
							if (!mode_q)
								res.status = fep_pkg::ST_NO_MODE;
							else if (sticky_q)
								res.status = fep_pkg::ST_OP_FAIL;
						end
						default: begin
							emit      = 1'b1;
							pop       = 1'b1;
							do_report = 1'b1;
							if (sticky_q || head.op_failed)
								res.status = fep_pkg::ST_OP_FAIL;
						end
					endcase
				end
			end
			fep_pkg::BK_ERASE: begin
				if (out_free) begin
					emit = 1'b1;
					if (more_erase) begin
						res.last = 1'b0;
						if (blk_ok) begin
							erase_blk      = 1'b1;
							res.cmd_kind   = fep_pkg::CMD_ERASE_BLOCK;
							res.cmd_target = fep_pkg::ADDR_W'(cursor_q >> fep_pkg::BLOCK_SHIFT);
						end else begin
							erase_sec      = 1'b1;
							res.cmd_kind   = fep_pkg::CMD_ERASE_SECTOR;
							res.cmd_target = fep_pkg::ADDR_W'(cursor_q);
						end
					end else begin
						do_write       = 1'b1;
						pop            = 1'b1;
						res.cmd_kind   = fep_pkg::CMD_WRITE;
						res.cmd_target = waddr_q;
						res.cmd_length = head.data_length;
					end
				end
			end
			default: ;
		endcase
	end

	// Session state, sequencer and output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fep_pkg::BK_IDLE;
			mode_q      <= 1'b0;
			waddr_q     <= '0;
			cursor_q    <= '0;
			left_q      <= '0;
			sticky_q    <= 1'b0;
			nerase_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (!rsp_stall)
				out_valid_q <= 1'b0;
			if (do_begin) begin
				mode_q   <= 1'b1;
				waddr_q  <= head.start_address;
				cursor_q <= fep_pkg::CURSOR_W'(head.start_address >> fep_pkg::SECTOR_SHIFT);
				left_q   <= head.sectors_left;
				sticky_q <= 1'b0;
			end
			if (do_end)
				mode_q <= 1'b0;
			if (do_report && head.op_failed)
				sticky_q <= 1'b1;
			if (start_data)
				nerase_q <= '0;
			if (erase_blk) begin
				cursor_q <= cursor_q + fep_pkg::CURSOR_W'(fep_pkg::SECTORS_IN_BLOCK);
				left_q   <= left_q - fep_pkg::LEFT_W'(fep_pkg::SECTORS_IN_BLOCK);
				nerase_q <= nerase_q + 1'b1;
			end
			if (erase_sec) begin
				cursor_q <= cursor_q + 1'b1;
				if (left_q != '0)
					left_q <= left_q - 1'b1;
				nerase_q <= nerase_q + 1'b1;
			end
			if (do_write)
				waddr_q <= waddr_q + fep_pkg::ADDR_W'(head.data_length);
		end
	end

	// Capture the result word and the end-sector bound of the write
	always_ff @(posedge clk) begin
		if (emit)
			out_q <= res;
		if (start_data)
			end_q <= fep_pkg::END_W'(end_sum >> fep_pkg::SECTOR_SHIFT);
	end

endmodule

>>> src/flash_erase_ahead_planner_core.sv
// Channel | Direction | Handshake            | Word
// --------+-----------+----------------------+---------------------------------
// req     | in        | req_valid, req_stall | fep_pkg::req_t (one request)
// rsp     | out       | rsp_valid, rsp_stall | fep_pkg::rsp_t (one flash command)
//
// A request's word and byte total are registered in the front (the sector rounding is
// combinational behind that register) and reach the back through a two-word queue.
// Begin, end, report and bad-size requests give one result word each; a data request
// in a session first registers the end of its sector range, then issues up to five
// erases and the write, one command word each, from the back's command loop.
// arst_n clears the session state, the queue and both valid flags.
// A stalled rsp holds the back; req stalls when the queue and the front stage are full.
module flash_erase_ahead_planner_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  fep_pkg::req_t   req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output fep_pkg::rsp_t   rsp
);

	logic            push;
	fep_pkg::op_t    push_op;
	logic            queue_full;
	logic            pop;
	logic            head_valid;
	fep_pkg::op_t    head;

	fep_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.push       (push),
		.push_op    (push_op),
		.queue_full (queue_full)
	);

	fep_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	fep_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import fep_pkg::*;

	localparam int SHOWN_LIMIT    = 10;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int TAIL_CYCLES    = 20;
	localparam int TOTAL_ITEMS    = 420;
	localparam int QUIET_FROM     = 360;
	localparam int PAUSE_AT       = 200;

	// Expected flash command words, worked out from a private copy of the session state
	class erase_plan_board;
		logic                in_session;
		logic [ADDR_W-1:0]   write_addr;
		logic [CURSOR_W-1:0] cursor;
		logic [LEFT_W-1:0]   sectors_left;
		logic                write_failed;
		rsp_t                planned_cmds[$];
		int                  mismatches;

		function new();
			in_session   = 1'b0;
			write_addr   = '0;
			cursor       = '0;
			sectors_left = '0;
			write_failed = 1'b0;
			mismatches   = 0;
		endfunction

		function int pending();
			return planned_cmds.size();
		endfunction

		// queue one command; the session flag is taken after the state update
		function void plan(cmd_kind_t kind, logic [ADDR_W-1:0] target,
				logic [LEN_W-1:0] len, status_t st, logic fin);
			rsp_t c;
			c.cmd_kind       = kind;
			c.cmd_target     = target;
			c.cmd_length     = len;
			c.status         = st;
			c.session_active = in_session;
			c.last           = fin;
			planned_cmds.push_back(c);
		endfunction

		// advance the session state by one accepted request word
		function void note_request(req_t w);
			logic [63:0]       cnt64;
			logic [63:0]       bytes64;
			logic [63:0]       secs;
			logic [63:0]       end_sector;
			logic [ADDR_W-1:0] sec_no;
			logic [ADDR_W-1:0] tgt;
			int                n;
			case (w.req_type)
			REQ_BEGIN: begin
				if (w.block_bytes > MAX_BLOCK_BYTES) begin
					plan(CMD_STATUS, '0, '0, ST_BAD_SIZE, 1'b1);
				end else begin
					in_session   = 1'b1;
					write_addr   = w.start_address;
					sec_no       = w.start_address / SECTOR_BYTES;
					cursor       = sec_no[CURSOR_W-1:0];
					cnt64        = w.block_count;
					bytes64      = w.block_bytes;
					secs         = (cnt64 * bytes64 + SECTOR_BYTES - 1) / SECTOR_BYTES;
					sectors_left = (secs > LEFT_MAX) ? LEFT_MAX : secs[LEFT_W-1:0];
					write_failed = 1'b0;
					plan(CMD_UNLOCK, '0, '0, ST_OK, 1'b1);
				end
			end
			REQ_DATA: begin
				if (!in_session) begin
					plan(CMD_STATUS, '0, '0, ST_NO_MODE, 1'b1);
				end else begin
					// erase ahead up to the sector of the last byte, without wrap
					end_sector = ({32'b0, write_addr} + w.data_length + SECTOR_BYTES - 1)
						/ SECTOR_BYTES;
					n = 0;
					while (n < MAX_ERASES && cursor < end_sector) begin
						if (cursor % SECTORS_IN_BLOCK == 0 && sectors_left > SECTORS_IN_BLOCK) begin
							tgt = cursor / SECTORS_IN_BLOCK;
							plan(CMD_ERASE_BLOCK, tgt, '0, ST_OK, 1'b0);
							cursor       = cursor + SECTORS_IN_BLOCK;
							sectors_left = sectors_left - SECTORS_IN_BLOCK;
						end else begin
							tgt = cursor;
							plan(CMD_ERASE_SECTOR, tgt, '0, ST_OK, 1'b0);
							cursor = cursor + 1;
							if (sectors_left != 0)
								sectors_left = sectors_left - 1;
						end
						n++;
					end
					plan(CMD_WRITE, write_addr, w.data_length, ST_OK, 1'b1);
					write_addr = write_addr + w.data_length;
				end
			end
			REQ_END: begin
				if (!in_session) begin
					plan(CMD_STATUS, '0, '0, ST_NO_MODE, 1'b1);
				end else begin
					in_session = 1'b0;
					plan(CMD_STATUS, '0, '0, write_failed ? ST_OP_FAIL : ST_OK, 1'b1);
				end
			end
			default: begin
				if (w.op_failed)
					write_failed = 1'b1;
				plan(CMD_STATUS, '0, '0, write_failed ? ST_OP_FAIL : ST_OK, 1'b1);
			end
			endcase
		endfunction

		function string describe(rsp_t c);
			return $sformatf("kind=%0d target=%h len=%0d status=%0d active=%b last=%b",
				c.cmd_kind, c.cmd_target, c.cmd_length, c.status, c.session_active, c.last);
		endfunction

		// compare one accepted command word with the oldest planned one
		function void check_result(rsp_t got);
			rsp_t  want;
			string diff;
			if (planned_cmds.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_LIMIT)
					$display("unplanned command word: %s", describe(got));
				return;
			end
			want = planned_cmds.pop_front();
			diff = "";
			if (got.cmd_kind !== want.cmd_kind)             diff = {diff, " kind"};
			if (got.cmd_target !== want.cmd_target)         diff = {diff, " target"};
			if (got.cmd_length !== want.cmd_length)         diff = {diff, " length"};
			if (got.status !== want.status)                 diff = {diff, " status"};
			if (got.session_active !== want.session_active) diff = {diff, " active"};
			if (got.last !== want.last)                     diff = {diff, " last"};
			if (diff != "") begin
				mismatches++;
				if (mismatches <= SHOWN_LIMIT)
					$display("command word mismatch (%s): expected %s, got %s",
						diff, describe(want), describe(got));
			end
		endfunction
	endclass

	logic  clk;
	logic  arst_n;
	logic  req_valid;
	logic  req_stall;
	req_t  req;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	erase_plan_board board;
	int              items_sent = 0;
	bit              quiet = 1'b0;
	int              rsp_hold_left = 0;
	int              stuck_cycles = 0;

	flash_erase_ahead_planner_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// stall the command side in short random bursts, never in the quiet tail
	always @(posedge clk) begin
		if (!arst_n || quiet) begin
			rsp_hold_left = 0;
			rsp_stall <= 1'b0;
		end else if (rsp_hold_left > 0) begin
			rsp_hold_left--;
			rsp_stall <= 1'b1;
		end else if ($urandom_range(5) == 0) begin
			rsp_hold_left = $urandom_range(4, 1) - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// check every accepted command word
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			board.check_result(rsp);
	end

	// abort when neither side has moved a word for too long
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL flash_erase_ahead_planner_core");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// offer one request word, with an optional idle burst ahead of it
	task automatic send_word(input req_t w);
		int gap;
		if (!quiet && $urandom_range(3) == 0) begin
			gap = $urandom_range(4, 1);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		board.note_request(w);
		items_sent++;
		if (items_sent >= QUIET_FROM)
			quiet = 1'b1;
	endtask

	task automatic send_req(input req_type_t t, input logic [ADDR_W-1:0] addr,
			input logic [COUNT_W-1:0] cnt, input logic [BYTES_W-1:0] bytes,
			input logic [LEN_W-1:0] len, input logic failed);
		req_t w;
		w.req_type      = t;
		w.start_address = addr;
		w.block_count   = cnt;
		w.block_bytes   = bytes;
		w.data_length   = len;
		w.op_failed     = failed;
		send_word(w);
	endtask

	// hold the sender until every planned command has come out
	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	function automatic req_t random_word(input req_type_t t);
		req_t w;
		w.req_type      = t;
		w.start_address = $urandom;
		w.block_count   = $urandom_range(0, 20'hFFFFF);
		w.block_bytes   = $urandom_range(0, 16'hFFFF);
		w.data_length   = $urandom_range(0, MAX_BLOCK_BYTES);
		w.op_failed     = $urandom_range(1);
		return w;
	endfunction

	task automatic run_directed();
		// outside a session: data and end refused, report still recorded
		send_req(REQ_DATA,   '0, '0, '0, 15'd16384, 1'b0);
		send_req(REQ_END,    '0, '0, '0, '0, 1'b0);
		send_req(REQ_REPORT, '0, '0, '0, '0, 1'b1);
		send_req(REQ_REPORT, '1, '1, '1, '0, 1'b0);
		// bad block sizes, largest and just over the limit
		send_req(REQ_BEGIN, 32'hFFFFFFFF, 20'hFFFFF, 16'hFFFF, '0, 1'b0);
		send_req(REQ_BEGIN, 32'h00002000, 20'd1, MAX_BLOCK_BYTES + 1, '0, 1'b0);
		// top of flash: erase cap hit while the cursor wraps, then address wrap
		send_req(REQ_BEGIN, 32'hFFFFF000, '0, MAX_BLOCK_BYTES, '0, 1'b0);
		send_req(REQ_DATA,  '0, '0, '0, 15'd16384, 1'b0);
		send_req(REQ_DATA,  '0, '0, '0, '0, 1'b0);
		send_req(REQ_REPORT, '0, '0, '0, '0, 1'b1);
		send_req(REQ_END,    '0, '0, '0, '0, 1'b0);
		// block-aligned start with a huge announced size: whole-block erase
		send_req(REQ_BEGIN, 32'h00010000, 20'hFFFFF, MAX_BLOCK_BYTES, '0, 1'b0);
		send_req(REQ_DATA,  '0, '0, '0, 15'd16384, 1'b0);
		send_req(REQ_DATA,  '0, '0, '0, 15'd1, 1'b0);
		send_req(REQ_REPORT, '0, '0, '0, '0, 1'b0);
		send_req(REQ_END,    '0, '0, '0, '0, 1'b0);
		// unaligned start, small budget: sector erases drain the count to zero and hold it there
		send_req(REQ_BEGIN, 32'h00001800, 20'd3, 16'd4096, '0, 1'b0);
		send_req(REQ_DATA,  '0, '0, '0, 15'd16384, 1'b0);
		send_req(REQ_DATA,  '0, '0, '0, 15'd16384, 1'b0);
		// begin inside a session at the last byte, zero size
		send_req(REQ_BEGIN, 32'hFFFFFFFF, 20'd1, '0, '0, 1'b0);
		send_req(REQ_DATA,  '0, '0, '0, 15'd1, 1'b0);
		// exactly one block of sectors left: sector erases, not a block
		send_req(REQ_BEGIN, 32'h00100000, 20'd4, MAX_BLOCK_BYTES, '0, 1'b0);
		send_req(REQ_DATA,  '0, '0, '0, 15'd16384, 1'b0);
		send_req(REQ_END,   '0, '0, '0, '0, 1'b0);
	endtask

	// one mostly well-formed session with random content
	task automatic run_session();
		req_t w;
		int   n_data;
		w = random_word(REQ_BEGIN);
		case ($urandom_range(3))
		0: w.start_address = $urandom & 32'hFFFF0000;
		1: w.start_address = 32'hFFFF0000 | ($urandom & 32'h0000FFFF);
		2: w.start_address = $urandom_range(0, 32'h0003FFFF);
		default: ;
		endcase
		case ($urandom_range(2))
		0: w.block_count = $urandom_range(0, 64);
		1: w.block_count = $urandom_range(0, 4);
		default: ;
		endcase
		if ($urandom_range(7) != 0)
			w.block_bytes = $urandom_range(0, MAX_BLOCK_BYTES);
		send_word(w);
		n_data = $urandom_range(8, 1);
		repeat (n_data) begin
			if ($urandom_range(4) == 0)
				send_word(random_word(REQ_REPORT));
			w = random_word(REQ_DATA);
			case ($urandom_range(3))
			0: w.data_length = MAX_BLOCK_BYTES;
			1: w.data_length = $urandom_range(0, 255);
			default: ;
			endcase
			send_word(w);
		end
		if ($urandom_range(7) != 0)
			send_word(random_word(REQ_END));
	endtask

	initial begin
		bit paused;
		paused    = 1'b0;
		board     = new();
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		wait_drained();

		// mostly sessions, some stray requests of any kind
		while (items_sent < TOTAL_ITEMS) begin
			if ($urandom_range(5) == 0)
				send_word(random_word(req_type_t'($urandom_range(3))));
			else
				run_session();
			if (!paused && items_sent >= PAUSE_AT) begin
				paused = 1'b1;
				wait_drained();
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("PASS flash_erase_ahead_planner_core");
		else
			$display("FAIL flash_erase_ahead_planner_core");
		$finish;
	end

endmodule
